FILE: src/dmc_pkg.sv
`timescale 1ns / 1ps

package dmc_pkg;

    localparam int LINES       = 64;
    localparam int OFFSET_BITS = 2;
    localparam int ADDR_BITS   = 12;
    localparam int WORD_BITS   = 32;
    localparam int COUNT_BITS  = 32;

    localparam int LINE_LEN       = 1 << OFFSET_BITS;
    localparam int IDX_BITS       = $clog2(LINES);
    localparam int TAG_BITS       = ADDR_BITS - OFFSET_BITS - IDX_BITS;
    localparam int DATA_ADDR_BITS = IDX_BITS + OFFSET_BITS;
    localparam int MEM_WORDS      = 1 << ADDR_BITS;
    localparam int DATA_WORDS     = LINES * LINE_LEN;
    localparam int FILL_CNT_BITS  = OFFSET_BITS + 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic lookup;
        logic fill;
    } dmc_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic clear_last;
        logic hit;
        logic fill_last;
    } dmc_status_t;

endpackage

FILE: src/dmc_ctrl.sv
`timescale 1ns / 1ps

module dmc_ctrl import dmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  dmc_status_t status,
    output dmc_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_FILL
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        cmd.clear   = (state_reg == S_CLEAR);
        cmd.capture = (state_reg == S_IDLE) && start;
        cmd.lookup  = (state_reg == S_LOOKUP);
        cmd.fill    = (state_reg == S_FILL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    if (status.clear_last)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_LOOKUP;
                        busy_reg  <= 1'b1;
                    end
                end
                S_LOOKUP:
                begin
                    if (status.hit)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    if (status.fill_last)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: src/dmc_datapath.sv
`timescale 1ns / 1ps

module dmc_datapath import dmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dmc_cmd_t              cmd,
    output dmc_status_t           status,
    input  logic                  action,
    input  logic [ADDR_BITS-1:0]  word_address,
    input  logic [WORD_BITS-1:0]  write_word,
    output logic [WORD_BITS-1:0]  read_word,
    output logic                  was_hit,
    output logic [COUNT_BITS-1:0] hit_total,
    output logic [COUNT_BITS-1:0] miss_total
);

    logic [WORD_BITS-1:0] backing_mem [MEM_WORDS];
    logic [WORD_BITS-1:0] line_mem    [DATA_WORDS];
    logic [TAG_BITS-1:0]  tag_mem     [LINES];

    logic                     line_valid_reg [LINES];
    logic                     is_write_reg;
    logic [ADDR_BITS-1:0]     addr_reg;
    logic [WORD_BITS-1:0]     wdata_reg;
    logic [TAG_BITS-1:0]      tag_q_reg;
    logic [WORD_BITS-1:0]     line_q_reg;
    logic [ADDR_BITS-1:0]     clr_cnt_reg;
    logic [FILL_CNT_BITS-1:0] fill_cnt_reg;
    logic [WORD_BITS-1:0]     back_rd_reg;
    logic [WORD_BITS-1:0]     fill_word_reg;
    logic [WORD_BITS-1:0]     read_word_reg;
    logic                     was_hit_reg;
    logic [COUNT_BITS-1:0]    hit_count_reg;
    logic [COUNT_BITS-1:0]    miss_count_reg;

    logic [OFFSET_BITS-1:0]    req_off;
    logic [IDX_BITS-1:0]       req_idx;
    logic [TAG_BITS-1:0]       req_tag;
    logic [OFFSET_BITS-1:0]    in_off;
    logic [IDX_BITS-1:0]       in_idx;
    logic                      hit;
    logic                      fill_last;
    logic [FILL_CNT_BITS-1:0]  fill_prev;
    logic [OFFSET_BITS-1:0]    fill_off;
    logic                      fill_wr_en;
    logic                      fill_match;
    logic [WORD_BITS-1:0]      fill_wdata;
    logic                      hit_done;
    logic                      miss_done;

    logic                      lm_we;
    logic [DATA_ADDR_BITS-1:0] lm_waddr;
    logic [WORD_BITS-1:0]      lm_wdata;
    logic                      bm_we;
    logic [ADDR_BITS-1:0]      bm_waddr;
    logic [WORD_BITS-1:0]      bm_wdata;
    logic [ADDR_BITS-1:0]      bm_raddr;

    assign req_off = addr_reg[OFFSET_BITS-1:0];
    assign req_idx = addr_reg[OFFSET_BITS +: IDX_BITS];
    assign req_tag = addr_reg[ADDR_BITS-1 -: TAG_BITS];
    assign in_off  = word_address[OFFSET_BITS-1:0];
    assign in_idx  = word_address[OFFSET_BITS +: IDX_BITS];

    assign hit       = line_valid_reg[req_idx] && (tag_q_reg == req_tag);
    assign fill_last = (fill_cnt_reg == FILL_CNT_BITS'(LINE_LEN));
    assign fill_prev = fill_cnt_reg - FILL_CNT_BITS'(1);
    assign fill_off  = fill_prev[OFFSET_BITS-1:0];

    // The fill is pipelined: one backing read is issued per cycle and the
    // word read in the previous cycle is written into the line.
    assign fill_wr_en = cmd.fill && (fill_cnt_reg != '0);
    assign fill_match = (fill_off == req_off);
    assign fill_wdata = (is_write_reg && fill_match) ? wdata_reg : back_rd_reg;

    assign hit_done  = cmd.lookup && hit;
    assign miss_done = cmd.fill && fill_last;

    assign bm_raddr = {addr_reg[ADDR_BITS-1:OFFSET_BITS], fill_cnt_reg[OFFSET_BITS-1:0]};

    always_comb
    begin
        lm_we    = 1'b0;
        lm_waddr = {req_idx, req_off};
        lm_wdata = wdata_reg;
        if (hit_done && is_write_reg)
        begin
            lm_we = 1'b1;
        end
        else if (fill_wr_en)
        begin
            lm_we    = 1'b1;
            lm_waddr = {req_idx, fill_off};
            lm_wdata = fill_wdata;
        end
    end

    always_comb
    begin
        bm_we    = 1'b0;
        bm_waddr = addr_reg;
        bm_wdata = wdata_reg;
        if (cmd.clear)
        begin
            bm_we    = 1'b1;
            bm_waddr = clr_cnt_reg;
            bm_wdata = '0;
        end
        else if ((hit_done || miss_done) && is_write_reg)
        begin
            bm_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            backing_mem[bm_waddr] <= bm_wdata;
        end
        if (cmd.fill && !fill_last)
        begin
            back_rd_reg <= backing_mem[bm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lm_we)
        begin
            line_mem[lm_waddr] <= lm_wdata;
        end
        if (cmd.capture)
        begin
            line_q_reg <= line_mem[{in_idx, in_off}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (miss_done)
        begin
            tag_mem[req_idx] <= req_tag;
        end
        if (cmd.capture)
        begin
            tag_q_reg <= tag_mem[in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_write_reg <= action;
            addr_reg     <= word_address;
            wdata_reg    <= write_word;
        end
        if (fill_wr_en && fill_match)
        begin
            fill_word_reg <= fill_wdata;
        end
        if (hit_done)
        begin
            read_word_reg <= is_write_reg ? wdata_reg : line_q_reg;
            was_hit_reg   <= 1'b1;
        end
        else if (miss_done)
        begin
            read_word_reg <= fill_match ? fill_wdata : fill_word_reg;
            was_hit_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                line_valid_reg[i] <= 1'b0;
            end
            clr_cnt_reg    <= '0;
            fill_cnt_reg   <= '0;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
            end
            if (cmd.lookup)
            begin
                fill_cnt_reg <= '0;
            end
            else if (cmd.fill)
            begin
                fill_cnt_reg <= fill_cnt_reg + FILL_CNT_BITS'(1);
            end
            if (hit_done)
            begin
                hit_count_reg <= hit_count_reg + COUNT_BITS'(1);
            end
            if (miss_done)
            begin
                miss_count_reg          <= miss_count_reg + COUNT_BITS'(1);
                line_valid_reg[req_idx] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        status.clear_last = (clr_cnt_reg == '1);
        status.hit        = hit;
        status.fill_last  = fill_last;
    end

    assign read_word  = read_word_reg;
    assign was_hit    = was_hit_reg;
    assign hit_total  = hit_count_reg;
    assign miss_total = miss_count_reg;

endmodule

FILE: src/direct_mapped_write_through_cache_top.sv
// A hit is resolved in the lookup state, through the registered tag and data memory
// reads, and done follows it. A miss then runs a line fill, which reads the
// 2^OFFSET_BITS words of the line from the backing memory one word per cycle.
// Results are strobed on done for one cycle and cannot be stalled. After reset
// all 2^ADDR_BITS (4096) words of the backing memory are cleared, one word per
// cycle, with busy held high.
`timescale 1ns / 1ps

module direct_mapped_write_through_cache_top import dmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    input  logic                  action,
    input  logic [ADDR_BITS-1:0]  word_address,
    input  logic [WORD_BITS-1:0]  write_word,
    output logic [WORD_BITS-1:0]  read_word,
    output logic                  was_hit,
    output logic [COUNT_BITS-1:0] hit_total,
    output logic [COUNT_BITS-1:0] miss_total
);

    dmc_cmd_t    cmd;
    dmc_status_t status;

    dmc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    dmc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .word_address (word_address),
        .write_word   (write_word),
        .read_word    (read_word),
        .was_hit      (was_hit),
        .hit_total    (hit_total),
        .miss_total   (miss_total)
    );

    // A result is only delivered once the block is free for a new request.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done raised while busy");

    // An accepted request always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // A miss result advances the miss count by one and leaves the hit count alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !was_hit) |->
            (miss_total == $past(miss_total) + 32'd1) && (hit_total == $past(hit_total)))
        else $error("miss counters out of step with result");

    // A hit result advances the hit count by one and leaves the miss count alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && was_hit) |->
            (hit_total == $past(hit_total) + 32'd1) && (miss_total == $past(miss_total)))
        else $error("hit counters out of step with result");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dmc_pkg::*;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOT_LINES     = 8;

    typedef struct {
        logic                 act;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] data;
        int                   gap;
        bit                   drain;
    } access_req_t;

    typedef struct {
        logic [WORD_BITS-1:0]  word;
        logic                  hit;
        logic [COUNT_BITS-1:0] hits;
        logic [COUNT_BITS-1:0] misses;
    } access_answer_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  action = ACT_READ;
    logic [ADDR_BITS-1:0]  word_address = '0;
    logic [WORD_BITS-1:0]  write_word = '0;
    logic                  busy;
    logic                  done;
    logic [WORD_BITS-1:0]  read_word;
    logic                  was_hit;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] miss_total;

    direct_mapped_write_through_cache_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .action       (action),
        .word_address (word_address),
        .write_word   (write_word),
        .read_word    (read_word),
        .was_hit      (was_hit),
        .hit_total    (hit_total),
        .miss_total   (miss_total)
    );

    always #CLK_HALF clk = ~clk;

    // Shadow copy of the cache and the memory behind it.
    logic                  line_ok    [LINES];
    logic [TAG_BITS-1:0]   line_owner [LINES];
    logic [WORD_BITS-1:0]  cached_word[DATA_WORDS];
    logic [WORD_BITS-1:0]  main_mem   [MEM_WORDS];
    logic [COUNT_BITS-1:0] hits_so_far = '0;
    logic [COUNT_BITS-1:0] misses_so_far = '0;

    access_req_t    access_queue[$];
    access_answer_t cache_answers[$];

    int n_errors = 0;
    int n_sent = 0;
    int n_back = 0;
    int n_total = 0;

    access_req_t staged_req;
    bit          staged = 1'b0;
    int          gap_left = 0;

    logic [ADDR_BITS-1:0] hot_addr[HOT_LINES];

    initial
    begin
        for (int i = 0; i < LINES; i++)
        begin
            line_ok[i] = 1'b0;
        end
        for (int i = 0; i < MEM_WORDS; i++)
        begin
            main_mem[i] = '0;
        end
    end

    function automatic access_answer_t predict_access(logic act, logic [ADDR_BITS-1:0] addr,
                                                      logic [WORD_BITS-1:0] data);
        access_answer_t         ans;
        logic [OFFSET_BITS-1:0] off;
        logic [IDX_BITS-1:0]    idx;
        logic [TAG_BITS-1:0]    tg;
        logic                   hit;
        off = addr[OFFSET_BITS-1:0];
        idx = addr[OFFSET_BITS +: IDX_BITS];
        tg  = addr[ADDR_BITS-1 -: TAG_BITS];
        hit = line_ok[idx] && (line_owner[idx] == tg);
        if (hit)
        begin
            hits_so_far = hits_so_far + 1'b1;
        end
        else
        begin
            for (int i = 0; i < LINE_LEN; i++)
            begin
                cached_word[{idx, i[OFFSET_BITS-1:0]}] = main_mem[{tg, idx, i[OFFSET_BITS-1:0]}];
            end
            line_owner[idx] = tg;
            line_ok[idx]    = 1'b1;
            misses_so_far   = misses_so_far + 1'b1;
        end
        if (act == ACT_WRITE)
        begin
            cached_word[{idx, off}] = data;
            main_mem[addr]          = data;
        end
        ans.word   = cached_word[{idx, off}];
        ans.hit    = hit;
        ans.hits   = hits_so_far;
        ans.misses = misses_so_far;
        return ans;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic [WORD_BITS-1:0] pick_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return $urandom;
    endfunction

    // Most addresses land on a small set of lines so that hits, evictions
    // and write-allocate all happen often; the rest cover the whole space.
    function automatic logic [ADDR_BITS-1:0] pick_addr();
        int                   r;
        logic [ADDR_BITS-1:0] a;
        r = $urandom_range(0, 99);
        a = hot_addr[$urandom_range(0, HOT_LINES - 1)];
        if (r < 55)
        begin
            a[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom_range(0, LINE_LEN - 1));
        end
        else if (r < 75)
        begin
            a[ADDR_BITS-1 -: TAG_BITS] = TAG_BITS'($urandom_range(0, (1 << TAG_BITS) - 1));
            a[OFFSET_BITS-1:0]         = OFFSET_BITS'($urandom_range(0, LINE_LEN - 1));
        end
        else
        begin
            a = ADDR_BITS'($urandom_range(0, MEM_WORDS - 1));
        end
        return a;
    endfunction

    task automatic add_access(logic act, logic [ADDR_BITS-1:0] addr,
                              logic [WORD_BITS-1:0] data, int gap, bit drain);
        access_req_t r;
        r.act   = act;
        r.addr  = addr;
        r.data  = data;
        r.gap   = gap;
        r.drain = drain;
        access_queue.push_back(r);
        n_total++;
    endtask

    task automatic add_phase(int count, bit quiet, int write_pct, bit drains);
        bit drain;
        for (int h = 0; h < HOT_LINES; h++)
        begin
            hot_addr[h] = ADDR_BITS'($urandom_range(0, MEM_WORDS - 1));
        end
        for (int i = 0; i < count; i++)
        begin
            drain = (i == 0) || (drains && ($urandom_range(0, 49) == 0));
            add_access(($urandom_range(0, 99) < write_pct) ? ACT_WRITE : ACT_READ,
                       pick_addr(), pick_data(), quiet ? 0 : pick_gap(), drain);
        end
    endtask

    // Directed requests first, then random phases.
    initial
    begin
        add_access(ACT_READ,  12'h000, 32'h1234_5678, 0, 1'b0);  // cold miss reads zero
        add_access(ACT_READ,  12'h000, '0,            0, 1'b0);  // hit
        add_access(ACT_READ,  12'h003, '1,            0, 1'b0);  // hit, last word in line
        add_access(ACT_WRITE, 12'hFFF, '1,            0, 1'b0);  // write miss allocates
        add_access(ACT_READ,  12'hFFF, '0,            1, 1'b0);
        add_access(ACT_READ,  12'hFFC, '0,            0, 1'b0);  // neighbor in filled line
        add_access(ACT_WRITE, 12'h000, 32'hAAAA_AAAA, 0, 1'b0);  // write hit
        add_access(ACT_READ,  12'hF00, '0,            0, 1'b0);  // conflict evicts line 0
        add_access(ACT_READ,  12'h000, '0,            0, 1'b1);  // refill sees written data
        add_access(ACT_WRITE, 12'h001, 32'h5555_5555, 2, 1'b0);
        add_access(ACT_WRITE, 12'h001, '0,            0, 1'b0);
        add_access(ACT_READ,  12'h001, '1,            0, 1'b0);
        add_access(ACT_WRITE, 12'h123, 32'hDEAD_BEEF, 0, 1'b0);
        add_access(ACT_READ,  12'h121, '0,            0, 1'b0);
        add_access(ACT_READ,  12'h123, '0,            0, 1'b0);
        add_access(ACT_WRITE, 12'h0FF, '1,            0, 1'b0);
        add_access(ACT_WRITE, 12'hF0F, 32'h0F0F_0F0F, 0, 1'b0);
        add_access(ACT_READ,  12'h0FF, '0,            0, 1'b0);
        add_access(ACT_READ,  12'hF0F, '0,            5, 1'b1);
        add_access(ACT_READ,  12'h800, '0,            0, 1'b0);
        add_access(ACT_WRITE, 12'h7FF, 32'h8000_0001, 0, 1'b0);
        add_access(ACT_READ,  12'h7FC, '0,            0, 1'b0);
        add_phase(275, 1'b1, 50, 1'b0);
        add_phase(275, 1'b0, 40, 1'b0);
        add_phase(275, 1'b0, 50, 1'b1);
        add_phase(275, 1'b0, 75, 1'b1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent != n_total)
            @(negedge clk);
        while (cache_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (n_errors == 0)
            $display("direct_mapped_write_through_cache_top regression: pass");
        else
            $display("direct_mapped_write_through_cache_top regression: fail");
        $finish;
    end

    // Request driver.
    always @(posedge clk)
    begin
        access_answer_t ans;
        if (rst_n)
        begin
            if (done)
                n_back = n_back + 1;
            if (start && !busy)
            begin
                ans = predict_access(action, word_address, write_word);
                cache_answers.push_back(ans);
                n_sent = n_sent + 1;
            end
            if (!start || !busy)
            begin
                if (!staged && access_queue.size() != 0)
                begin
                    staged_req = access_queue.pop_front();
                    staged     = 1'b1;
                    gap_left   = staged_req.gap;
                end
                if (staged && gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end
                else if (staged && staged_req.drain && n_sent != n_back)
                begin
                    start <= 1'b0;
                end
                else if (staged)
                begin
                    start        <= 1'b1;
                    action       <= staged_req.act;
                    word_address <= staged_req.addr;
                    write_word   <= staged_req.data;
                    staged = 1'b0;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        access_answer_t exp_ans;
        if (rst_n && done)
        begin
            if (cache_answers.size() == 0)
            begin
                $error("result strobed with no request outstanding");
                n_errors++;
            end
            else
            begin
                exp_ans = cache_answers.pop_front();
                if (read_word !== exp_ans.word)
                begin
                    $error("read_word expected %h actual %h", exp_ans.word, read_word);
                    n_errors++;
                end
                if (was_hit !== exp_ans.hit)
                begin
                    $error("was_hit expected %0d actual %0d", exp_ans.hit, was_hit);
                    n_errors++;
                end
                if (hit_total !== exp_ans.hits)
                begin
                    $error("hit_total expected %0d actual %0d", exp_ans.hits, hit_total);
                    n_errors++;
                end
                if (miss_total !== exp_ans.misses)
                begin
                    $error("miss_total expected %0d actual %0d", exp_ans.misses, miss_total);
                    n_errors++;
                end
            end
        end
    end

    // The memory clear after reset keeps busy high while all MEM_WORDS words are written,
    // so the stall limit sits well above the time that takes.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("direct_mapped_write_through_cache_top regression: fail");
                $finish;
            end
        end
    end

endmodule
